// ===== design/assert_macros.svh =====
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcc_pkg.sv =====
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int LIN_W  = COL_W + ROW_W + 1;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    localparam logic [2:0] CUR_NONE    = 3'd0;
    localparam logic [2:0] CUR_NEWLINE = 3'd1;
    localparam logic [2:0] CUR_COL0    = 3'd2;
    localparam logic [2:0] CUR_BACK    = 3'd3;
    localparam logic [2:0] CUR_INC     = 3'd4;
    localparam logic [2:0] CUR_SET     = 3'd5;
    localparam logic [2:0] CUR_HOME    = 3'd6;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_GLYPH = 2'd1;
    localparam logic [1:0] MEM_BLANK = 2'd2;
    localparam logic [1:0] MEM_READ  = 2'd3;

    localparam logic [1:0] SW_NONE = 2'd0;
    localparam logic [1:0] SW_FILL = 2'd1;
    localparam logic [1:0] SW_COPY = 2'd2;

    localparam logic [1:0] ST_ZERO = 2'd0;
    localparam logic [1:0] ST_LAST = 2'd1;
    localparam logic [1:0] ST_COPY = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic [2:0] cur_op;
        logic [1:0] mem_op;
        logic [1:0] sweep_op;
        logic       sweep_init;
        logic       sweep_load;
        logic [1:0] sweep_start;
        logic       out_load;
        logic       out_cell;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             is_newline;
        logic             is_backspace;
        logic             at_origin;
        logic             col_full;
        logic             last_row;
        logic             cell_in_grid;
        logic             fill_last;
        logic             copy_last;
        logic             out_free;
    } sts_t;

endpackage

// ===== design/tcc_ctrl.sv =====
`timescale 1ns / 1ps

module tcc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tcc_pkg::sts_t sts,
    output tcc_pkg::ctl_t ctl
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_BLANK = 3'd3;
    localparam logic [2:0] S_GLYPH = 3'd4;
    localparam logic [2:0] S_COPY  = 3'd5;
    localparam logic [2:0] S_FILL  = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       pend_glyph_reg;
    logic       pend_glyph_next;
    logic       read_hit_reg;
    logic       read_hit_next;
    logic       glyph;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            pend_glyph_reg <= 1'b0;
            read_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_glyph_reg <= pend_glyph_next;
            read_hit_reg   <= read_hit_next;
        end
    end

    assign glyph = !sts.is_newline && !sts.is_backspace;

    always_comb
    begin
        ctl             = '0;
        ctl.cur_op      = tcc_pkg::CUR_NONE;
        ctl.mem_op      = tcc_pkg::MEM_NONE;
        ctl.sweep_op    = tcc_pkg::SW_NONE;
        ctl.sweep_start = tcc_pkg::ST_ZERO;
        state_next      = state_reg;
        pend_glyph_next = pend_glyph_reg;
        read_hit_next   = read_hit_reg;
        in_ready        = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                ctl.sweep_op   = tcc_pkg::SW_FILL;
                ctl.sweep_init = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                pend_glyph_next = 1'b0;
                read_hit_next   = 1'b0;
                state_next      = S_RESP;
                unique case (sts.cmd)
                    tcc_pkg::CMD_PUT:
                    begin
                        priority if (sts.is_backspace)
                        begin
                            if (!sts.at_origin)
                            begin
                                ctl.cur_op = tcc_pkg::CUR_BACK;
                                state_next = S_BLANK;
                            end
                        end
                        else if (sts.is_newline || sts.col_full)
                        begin
                            if (!sts.last_row)
                            begin
                                ctl.cur_op = tcc_pkg::CUR_NEWLINE;
                                state_next = glyph ? S_GLYPH : S_RESP;
                            end
                            else
                            begin
                                ctl.cur_op      = tcc_pkg::CUR_COL0;
                                ctl.sweep_load  = 1'b1;
                                ctl.sweep_start = tcc_pkg::ST_COPY;
                                pend_glyph_next = glyph;
                                state_next      = S_COPY;
                            end
                        end
                        else
                        begin
                            ctl.mem_op = tcc_pkg::MEM_GLYPH;
                            ctl.cur_op = tcc_pkg::CUR_INC;
                        end
                    end
                    tcc_pkg::CMD_READ:
                    begin
                        if (sts.cell_in_grid)
                        begin
                            ctl.mem_op    = tcc_pkg::MEM_READ;
                            read_hit_next = 1'b1;
                        end
                    end
                    tcc_pkg::CMD_SET:
                    begin
                        if (sts.cell_in_grid)
                        begin
                            ctl.cur_op = tcc_pkg::CUR_SET;
                        end
                    end
                    tcc_pkg::CMD_CLEAR:
                    begin
                        ctl.cur_op      = tcc_pkg::CUR_HOME;
                        ctl.sweep_load  = 1'b1;
                        ctl.sweep_start = tcc_pkg::ST_ZERO;
                        state_next      = S_FILL;
                    end
                endcase
            end
            S_BLANK:
            begin
                ctl.mem_op = tcc_pkg::MEM_BLANK;
                state_next = S_RESP;
            end
            S_GLYPH:
            begin
                ctl.mem_op = tcc_pkg::MEM_GLYPH;
                ctl.cur_op = tcc_pkg::CUR_INC;
                state_next = S_RESP;
            end
            S_COPY:
            begin
                ctl.sweep_op = tcc_pkg::SW_COPY;
                if (sts.copy_last)
                begin
                    ctl.sweep_load  = 1'b1;
                    ctl.sweep_start = tcc_pkg::ST_LAST;
                    state_next      = S_FILL;
                end
            end
            S_FILL:
            begin
                ctl.sweep_op = tcc_pkg::SW_FILL;
                if (sts.fill_last)
                begin
                    state_next = pend_glyph_reg ? S_GLYPH : S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_cell = read_hit_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tcc_datapath.sv =====
`timescale 1ns / 1ps

module tcc_datapath
#(
    parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcc_pkg::DEF_ROWS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcc_pkg::ctl_t                 ctl,
    output tcc_pkg::sts_t                 sts,
    input  logic [tcc_pkg::CMD_W-1:0]     in_cmd,
    input  logic [tcc_pkg::CHAR_W-1:0]    in_character,
    input  logic [tcc_pkg::COL_W-1:0]     in_cell_col,
    input  logic [tcc_pkg::ROW_W-1:0]     in_cell_row,
    input  logic                          cfg_we,
    input  logic [tcc_pkg::ATTR_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcc_pkg::POS_W-1:0]     out_cursor_pos,
    output logic [tcc_pkg::CHAR_W-1:0]    out_cell_char,
    output logic [tcc_pkg::ATTR_W-1:0]    out_cell_attr
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = tcc_pkg::COL_W;
    localparam int ROW_W      = tcc_pkg::ROW_W;
    localparam int LIN_W      = tcc_pkg::LIN_W;
    localparam int CELL_W     = tcc_pkg::CELL_W;
    localparam int CHAR_W     = tcc_pkg::CHAR_W;
    localparam int ATTR_W     = tcc_pkg::ATTR_W;

    logic [CELL_W-1:0] cells_mem [CELL_COUNT];

    logic [tcc_pkg::CMD_W-1:0] cmd_reg;
    logic [CHAR_W-1:0]         char_reg;
    logic [COL_W-1:0]          ccol_reg;
    logic [ROW_W-1:0]          crow_reg;

    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [ATTR_W-1:0] attr_reg;
    logic [CNT_W-1:0]  sweep_reg;
    logic [CNT_W-1:0]  sweep_next;
    logic              wr_pend_reg;
    logic              wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [CELL_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [tcc_pkg::POS_W-1:0] pos_reg;
    logic [CHAR_W-1:0] ochar_reg;
    logic [ATTR_W-1:0] oattr_reg;

    logic [LIN_W-1:0]  cur_lin;
    logic [LIN_W-1:0]  cell_lin;
    logic [CELL_W-1:0] blank_cell;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              copy_read;

    assign cur_lin  = LIN_W'(cur_row_reg) * LIN_W'(COLUMNS) + LIN_W'(cur_col_reg);
    assign cell_lin = LIN_W'(crow_reg) * LIN_W'(COLUMNS) + LIN_W'(ccol_reg);

    always_comb
    begin
        sts.cmd          = cmd_reg;
        sts.is_newline   = (char_reg == tcc_pkg::CH_NEWLINE);
        sts.is_backspace = (char_reg == tcc_pkg::CH_BACKSPACE);
        sts.at_origin    = (cur_col_reg == '0) && (cur_row_reg == '0);
        sts.col_full     = (cur_col_reg >= COL_W'(COLUMNS));
        sts.last_row     = (cur_row_reg >= ROW_W'(ROWS - 1));
        sts.cell_in_grid = (ccol_reg < COL_W'(COLUMNS)) && (crow_reg < ROW_W'(ROWS));
        sts.fill_last    = (sweep_reg == CNT_W'(CELL_COUNT - 1));
        sts.copy_last    = (sweep_reg == CNT_W'(CELL_COUNT));
        sts.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        unique case (ctl.cur_op)
            tcc_pkg::CUR_NONE:
            begin
            end
            tcc_pkg::CUR_NEWLINE:
            begin
                cur_col_next = '0;
                cur_row_next = cur_row_reg + ROW_W'(1);
            end
            tcc_pkg::CUR_COL0:
            begin
                cur_col_next = '0;
            end
            tcc_pkg::CUR_BACK:
            begin
                if (cur_col_reg == '0)
                begin
                    cur_col_next = COL_W'(COLUMNS - 1);
                    cur_row_next = cur_row_reg - ROW_W'(1);
                end
                else
                begin
                    cur_col_next = cur_col_reg - COL_W'(1);
                end
            end
            tcc_pkg::CUR_INC:
            begin
                cur_col_next = cur_col_reg + COL_W'(1);
            end
            tcc_pkg::CUR_SET:
            begin
                cur_col_next = ccol_reg;
                cur_row_next = crow_reg;
            end
            tcc_pkg::CUR_HOME:
            begin
                cur_col_next = '0;
                cur_row_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        priority if (ctl.sweep_load)
        begin
            unique case (ctl.sweep_start)
                tcc_pkg::ST_ZERO: sweep_next = '0;
                tcc_pkg::ST_LAST: sweep_next = CNT_W'((ROWS - 1) * COLUMNS);
                tcc_pkg::ST_COPY: sweep_next = CNT_W'(COLUMNS);
                default:          sweep_next = '0;
            endcase
        end
        else if (ctl.sweep_op == tcc_pkg::SW_FILL || copy_read)
        begin
            sweep_next = sweep_reg + CNT_W'(1);
        end
        else
        begin
            sweep_next = sweep_reg;
        end
    end

    // A scroll reads one row below and writes the cell in the next cycle, one cell a cycle.
    assign copy_read    = (ctl.sweep_op == tcc_pkg::SW_COPY) && !sts.copy_last;
    assign wr_pend_next = copy_read;

    assign blank_cell = {(ctl.sweep_init ? tcc_pkg::ATTR_RESET : attr_reg), tcc_pkg::CH_BLANK};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_lin[ADDR_W-1:0];
        mem_wdata = blank_cell;
        priority if (wr_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = rd_data_reg;
        end
        else if (ctl.sweep_op == tcc_pkg::SW_FILL)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg[ADDR_W-1:0];
        end
        else if (ctl.mem_op == tcc_pkg::MEM_GLYPH)
        begin
            mem_we    = 1'b1;
            mem_wdata = {attr_reg, char_reg};
        end
        else if (ctl.mem_op == tcc_pkg::MEM_BLANK)
        begin
            mem_we = 1'b1;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    assign mem_re    = copy_read || (ctl.mem_op == tcc_pkg::MEM_READ);
    assign mem_raddr = copy_read ? sweep_reg[ADDR_W-1:0] : cell_lin[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cells_mem[mem_raddr];
        end
    end

    assign out_valid_next = ctl.out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            attr_reg      <= tcc_pkg::ATTR_RESET;
            sweep_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            sweep_reg     <= sweep_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg  <= in_cmd;
            char_reg <= in_character;
            ccol_reg <= in_cell_col;
            crow_reg <= in_cell_row;
        end
        wr_addr_reg <= ADDR_W'(sweep_reg - CNT_W'(COLUMNS));
        if (ctl.out_load)
        begin
            pos_reg   <= cur_lin[tcc_pkg::POS_W-1:0];
            ochar_reg <= ctl.out_cell ? rd_data_reg[CHAR_W-1:0] : '0;
            oattr_reg <= ctl.out_cell ? rd_data_reg[CELL_W-1:CHAR_W] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_cursor_pos = pos_reg;
    assign out_cell_char  = ochar_reg;
    assign out_cell_attr  = oattr_reg;

endmodule

// ===== design/text_console_cursor_engine.sv =====
// Text console: a grid of COLUMNS x ROWS character cells and a cursor.
// Commands arrive as beats on the s_ channel, one beat per command, and each
// command returns exactly one result beat on the m_ channel: the cursor
// position after the command and, for a read inside the grid, its character
// and attribute. cfg_we writes the attribute byte used for every glyph and
// blank written from then on. A glyph, a newline without scroll, a cursor
// set or a cell read goes straight from execution to the result; a backspace
// or a glyph that wraps first passes through a blank or glyph write state.
// A newline or wrap on the last row scrolls the grid, one cell a cycle with
// one read and one write of the cell memory, then blanks the last row and
// writes the glyph when one follows. A clear fills every cell. One command is
// worked at a time, so no new beat is taken until the last command's result
// has been loaded for output. After reset the cell memory is filled with
// blanks in a pass over every cell, during which s_tready stays low.
// A finished result waits in an output register; the next command is taken
// while it waits, and that command's result holds until m_tready frees it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_cursor_engine
#(
    parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcc_pkg::DEF_ROWS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // character [7:0], cell_col [14:8], cell_row [19:15], zeros above
    input  logic [tcc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd [1:0]
    input  logic [tcc_pkg::CMD_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cursor_pos [10:0], cell_char [18:11], cell_attr [26:19], zeros above
    output logic [tcc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [tcc_pkg::ATTR_W-1:0]         cfg_data
);

    localparam int OUT_USED = tcc_pkg::POS_W + tcc_pkg::CHAR_W + tcc_pkg::ATTR_W;

    tcc_pkg::ctl_t ctl;
    tcc_pkg::sts_t sts;

    logic [tcc_pkg::POS_W-1:0]  cursor_pos;
    logic [tcc_pkg::CHAR_W-1:0] cell_char;
    logic [tcc_pkg::ATTR_W-1:0] cell_attr;

    tcc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tcc_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .in_cmd         (s_tuser),
        .in_character   (s_tdata[7:0]),
        .in_cell_col    (s_tdata[14:8]),
        .in_cell_row    (s_tdata[19:15]),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_cursor_pos (cursor_pos),
        .out_cell_char  (cell_char),
        .out_cell_attr  (cell_attr)
    );

    assign m_tdata = {{(tcc_pkg::OUT_TDATA_W - OUT_USED){1'b0}}, cell_attr, cell_char, cursor_pos};

    `ASSERT_IMPLIES(a_no_sweep_when_ready, clk, rst_n, s_tready, ctl.sweep_op == tcc_pkg::SW_NONE, "sweep active while accepting")
    `ASSERT_IMPLIES(a_single_write_alone, clk, rst_n, ctl.mem_op != tcc_pkg::MEM_NONE, ctl.sweep_op == tcc_pkg::SW_NONE, "cell access during sweep")
    `ASSERT_IMPLIES(a_load_when_free, clk, rst_n, ctl.out_load, sts.out_free, "result loaded over a waiting result")
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "second beat taken while busy")

endmodule

// ===== tb/text_console_cursor_engine_checker.sv =====
`timescale 1ns / 1ps

module text_console_cursor_engine_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // character [7:0], cell_col [14:8], cell_row [19:15], zeros above
    input  logic [tcc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd [1:0]
    input  logic [tcc_pkg::CMD_W-1:0]          s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // cursor_pos [10:0], cell_char [18:11], cell_attr [26:19], zeros above
    input  logic [tcc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [tcc_pkg::ATTR_W-1:0]         cfg_data,
    output int                                 mismatches,
    output int                                 pending
);

    import tcc_pkg::*;

    localparam int COLS   = DEF_COLUMNS;
    localparam int ROWS_N = DEF_ROWS;
    localparam int CELLS  = COLS * ROWS_N;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
    } report_t;

    logic [CELL_W-1:0] grid [0:CELLS-1];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] attr_now;
    report_t           due_reports [$];
    int                fault_count = 0;
    int                queued = 0;

    assign mismatches = fault_count;
    assign pending    = queued;

    function automatic logic [CELL_W-1:0] blank_cell();
        return {attr_now, CH_BLANK};
    endfunction

    task automatic wipe_screen();
        int i;
        for (i = 0; i < CELLS; i++)
            grid[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
    endtask

    task automatic line_feed();
        int i;
        cur_col = 0;
        if (cur_row + 1 < ROWS_N)
            cur_row++;
        else
        begin
            for (i = 0; i + COLS < CELLS; i++)
                grid[i] = grid[i + COLS];
            for (i = (ROWS_N - 1) * COLS; i < CELLS; i++)
                grid[i] = blank_cell();
        end
    endtask

    task automatic rub_out();
        if (cur_col != 0 || cur_row != 0)
        begin
            if (cur_col == 0)
            begin
                cur_row--;
                cur_col = COLS;
            end
            cur_col--;
            grid[cur_row * COLS + cur_col] = blank_cell();
        end
    endtask

    task automatic predict_report(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                  input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y,
                                  output report_t r);
        logic [CELL_W-1:0] cell_word;
        r = '0;
        case (cmd)
            CMD_PUT:
            begin
                if (ch == CH_NEWLINE)
                    line_feed();
                else if (ch == CH_BACKSPACE)
                    rub_out();
                else
                begin
                    if (cur_col >= COLS)
                        line_feed();
                    grid[cur_row * COLS + cur_col] = {attr_now, ch};
                    cur_col++;
                end
            end
            CMD_READ:
            begin
                if (int'(x) < COLS && int'(y) < ROWS_N)
                begin
                    cell_word = grid[int'(y) * COLS + int'(x)];
                    r.ch      = cell_word[CHAR_W-1:0];
                    r.attr    = cell_word[CELL_W-1:CHAR_W];
                end
            end
            CMD_SET:
            begin
                if (int'(x) < COLS && int'(y) < ROWS_N)
                begin
                    cur_col = int'(x);
                    cur_row = int'(y);
                end
            end
            default:
                wipe_screen();
        endcase
        r.pos = POS_W'(cur_row * COLS + cur_col);
    endtask

    always @(posedge clk)
    begin : watch_beats
        report_t want;
        report_t got;
        if (!rst_n)
        begin
            attr_now = ATTR_RESET;
            wipe_screen();
            due_reports.delete();
            queued      = 0;
            fault_count = 0;
        end
        else
        begin
            if (cfg_we)
                attr_now = cfg_data;
            if (m_tvalid && m_tready)
            begin
                got.pos  = m_tdata[POS_W-1:0];
                got.ch   = m_tdata[POS_W+CHAR_W-1:POS_W];
                got.attr = m_tdata[POS_W+CHAR_W+ATTR_W-1:POS_W+CHAR_W];
                if (due_reports.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("result beat with no command outstanding: ",
                                 "pos %0d char %02h attr %02h",
                                 got.pos, got.ch, got.attr);
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (want != got)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch: expected pos %0d char %02h attr %02h, ",
                                     "got pos %0d char %02h attr %02h",
                                     want.pos, want.ch, want.attr,
                                     got.pos, got.ch, got.attr);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_report(s_tuser, s_tdata[7:0], s_tdata[14:8], s_tdata[19:15], want);
                due_reports.push_back(want);
            end
            queued = due_reports.size();
        end
    end

endmodule

// ===== tb/text_console_cursor_engine_tb.sv =====
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;

    import tcc_pkg::*;

    localparam int COLS           = DEF_COLUMNS;
    localparam int ROWS_N         = DEF_ROWS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 100;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [ATTR_W-1:0]      cfg_data;

    int mismatches;
    int pending;
    int results_seen = 0;
    int issued = 0;
    int stall_cycles;
    bit calm = 1'b0;

    always #4 clk = ~clk;

    text_console_cursor_engine uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    text_console_cursor_engine_checker watch
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge clk)
        if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;

    initial
    begin : receiver
        int holds_done;
        holds_done = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && holds_done < 2 && results_seen >= 150 + 250 * holds_done)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic issue(input logic [CMD_W-1:0] cmd, input int ch,
                         input int col, input int row);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, ROW_W'(row), COL_W'(col), CHAR_W'(ch)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        issued++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic int glyph_byte();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return int'(CH_NEWLINE);
        else if (p < 18)
            return int'(CH_BACKSPACE);
        else
            return int'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(input int items);
        int start;
        int pick;
        int burst;
        int reads;
        int k;
        int sx;
        int sy;
        start = issued;
        while (issued - start < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                sx = int'($urandom_range(0, COLS - 1));
                sy = ($urandom_range(0, 3) == 0) ? ROWS_N - 1
                                                 : int'($urandom_range(0, ROWS_N - 1));
                issue(CMD_SET, int'($urandom), sx, sy);
                burst = int'($urandom_range(1, 16));
                for (k = 0; k < burst; k++)
                    issue(CMD_PUT, glyph_byte(), int'($urandom), int'($urandom));
                reads = int'($urandom_range(1, 3));
                for (k = 0; k < reads; k++)
                    issue(CMD_READ, int'($urandom), sx + int'($urandom_range(0, burst)),
                          sy + int'($urandom_range(0, 1)));
            end
            else if (pick < 75)
                issue(CMD_READ, int'($urandom), int'($urandom), int'($urandom));
            else if (pick < 85)
                issue(CMD_SET, int'($urandom), int'($urandom), int'($urandom));
            else if (pick < 98)
                issue(CMD_PUT, int'($urandom), int'($urandom), int'($urandom));
            else
                issue(CMD_CLEAR, int'($urandom), int'($urandom), int'($urandom));
        end
    endtask

    initial
    begin : stimulus
        logic [ATTR_W-1:0] attrs [0:5];
        int p;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_PUT;
        cfg_we   = 1'b0;
        cfg_data = '0;
        attrs[0] = 8'h00;
        attrs[1] = 8'hFF;
        attrs[2] = ATTR_W'($urandom);
        attrs[3] = 8'hA5;
        attrs[4] = ATTR_W'($urandom);
        attrs[5] = 8'h5A;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(CMD_READ, 0, 0, 0);
        issue(CMD_READ, 255, 127, 31);
        issue(CMD_READ, 0, COLS - 1, ROWS_N - 1);
        issue(CMD_PUT, 65, 0, 0);
        issue(CMD_PUT, 255, 127, 31);
        issue(CMD_PUT, 0, 0, 0);
        issue(CMD_PUT, int'(CH_BACKSPACE), 0, 0);
        issue(CMD_READ, 0, 1, 0);
        issue(CMD_READ, 0, 2, 0);
        issue(CMD_SET, 0, 0, 5);
        issue(CMD_PUT, int'(CH_BACKSPACE), 0, 0);
        issue(CMD_SET, 0, COLS, 3);
        issue(CMD_SET, 0, 10, ROWS_N);
        issue(CMD_SET, 0, COLS - 1, ROWS_N - 1);
        issue(CMD_PUT, 90, 0, 0);
        issue(CMD_PUT, 81, 0, 0);
        issue(CMD_READ, 0, COLS - 1, ROWS_N - 2);
        issue(CMD_READ, 0, 0, ROWS_N - 1);
        issue(CMD_PUT, int'(CH_NEWLINE), 0, 0);
        issue(CMD_READ, 0, 0, ROWS_N - 2);
        issue(CMD_SET, 0, 5, 2);
        issue(CMD_PUT, int'(CH_NEWLINE), 0, 0);
        issue(CMD_SET, 0, COLS - 2, 7);
        issue(CMD_PUT, 97, 0, 0);
        issue(CMD_PUT, 98, 0, 0);
        issue(CMD_PUT, int'(CH_BACKSPACE), 0, 0);
        issue(CMD_READ, 0, COLS - 1, 7);
        issue(CMD_CLEAR, 255, 127, 31);
        issue(CMD_PUT, int'(CH_BACKSPACE), 0, 0);
        issue(CMD_READ, 0, 0, 0);

        for (p = 0; p < 6; p++)
        begin
            settle();
            write_attr(attrs[p]);
            if (p == 5)
                calm <= 1'b1;
            random_phase(PHASE_ITEMS);
        end

        settle();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
